// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// when pre holds, post holds in the same cycle
`define ASSERT_IMPLY(lbl, pre, post, msg) \
	`ASSERT_CLK(lbl, (pre) |-> (post), msg)

// cond never holds
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: src/bfpb_pkg.sv
package bfpb_pkg;

	// command codes carried in s_tuser
	localparam logic [2:0] CMD_LOAD      = 3'd0;
	localparam logic [2:0] CMD_BEGIN     = 3'd1;
	localparam logic [2:0] CMD_BEGIN_CTR = 3'd2;
	localparam logic [2:0] CMD_DRAW      = 3'd3;
	localparam logic [2:0] CMD_CLEAR     = 3'd4;
	localparam logic [2:0] CMD_READ      = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_GLYPH_WIDTH = 2'd0;
	localparam logic [1:0] CFG_FIRST_CODE  = 2'd1;
	localparam logic [1:0] CFG_LAST_CODE   = 2'd2;

	localparam logic [4:0] GLYPH_WIDTH_RST = 5'd8;
	localparam logic [7:0] FIRST_CODE_RST  = 8'd32;
	localparam logic [7:0] LAST_CODE_RST   = 8'd127;

	// sections
	localparam logic [1:0] SEC_HEADER = 2'd0;
	localparam logic [1:0] SEC_BODY   = 2'd1;
	localparam logic [1:0] SEC_FOOTER = 2'd2;

	localparam logic [3:0] HEADER_FIRST_PAGE = 4'd0;
	localparam logic [3:0] HEADER_LAST_PAGE  = 4'd2;
	localparam logic [3:0] BODY_FIRST_PAGE   = 4'd3;
	localparam logic [3:0] BODY_LAST_PAGE    = 4'd5;
	localparam logic [3:0] FOOTER_FIRST_PAGE = 4'd6;
	localparam logic [3:0] FOOTER_LAST_PAGE  = 4'd7;

	localparam logic [2:0] SHIFT_MAX = 3'd7;

	// glyph base reduction: 13-bit value, five conditional subtract steps
	localparam int         RED_W   = 13;
	localparam logic [2:0] RED_TOP = 3'd4;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		FRD_USER,
		FRD_CUR,
		FRD_NEXT
	} frd_sel_t;

	typedef struct packed {
		logic     take;
		logic     decode;
		logic     red_step;
		logic     gly_wr;
		logic     begin_upd;
		logic     swp_load;
		logic     swp_step;
		frd_sel_t frd_sel;
		logic     col0;
		logic     col1;
		logic     adv;
		logic     rd_cap;
		logic     res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       sec_ok;
		logic       draw_ok;
		logic       shift_nz;
		logic       red_last;
		logic       swp_last;
		logic       col_last;
		logic       res_free;
	} dp_sts_t;

endpackage

// File: src/bitmap_font_page_blitter.sv
// Text renderer for a page-organized monochrome frame store (PAGES pages of COLUMNS bytes,
// bit 0 at the top of each column byte) with a loadable glyph memory of GLYPH_DEPTH bytes.
// Commands arrive as one beat on s_* and each gives exactly one result beat on m_*; the
// block handles one command at a time, and a new beat is taken while the previous result
// still waits on m_*. After reset s_tready stays low while the frame store is wiped. A load
// reduces the glyph address, then writes the glyph byte. A drawn character reduces its glyph
// base, then per glyph column reads the glyph byte with the cursor page byte and writes that
// page; with a vertical shift the next page is also read, modified and written. Clear wipes
// every page of the section. Durations are set by the frame store's single read and single
// write port and by the five-step reduction of the glyph address modulo the glyph memory
// depth. Configuration writes are always taken.
module bitmap_font_page_blitter #(
	parameter int COLUMNS     = 128,
	parameter int PAGES       = 8,
	parameter int GLYPH_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// section, start_column, row_in_section, vertical_shift, text_length, char_code,
	// glyph_address, glyph_byte, read_page, read_column, zero pad
	input  logic [71:0] s_tdata,
	// cmd
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data, cursor_column
	output logic [15:0] m_tdata,
	// status
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	bfpb_pkg::dp_cmd_t dp_cmd;
	bfpb_pkg::dp_sts_t dp_sts;

	assign cfg_ready = 1'b1;

	bfpb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (dp_sts),
		.cmd     (dp_cmd)
	);

	bfpb_dp #(
		.COLUMNS    (COLUMNS),
		.PAGES      (PAGES),
		.GLYPH_DEPTH(GLYPH_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule

// File: src/bfpb_ram.sv
module bfpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/bfpb_ctrl.sv
module bfpb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bfpb_pkg::dp_sts_t sts,
	output bfpb_pkg::dp_cmd_t cmd
);

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DECODE = 4'd2;
	localparam logic [3:0] ST_MOD    = 4'd3;
	localparam logic [3:0] ST_LOADW  = 4'd4;
	localparam logic [3:0] ST_BEGIN  = 4'd5;
	localparam logic [3:0] ST_SWEEP  = 4'd6;
	localparam logic [3:0] ST_RDW    = 4'd7;
	localparam logic [3:0] ST_GLY    = 4'd8;
	localparam logic [3:0] ST_COL0   = 4'd9;
	localparam logic [3:0] ST_COL1   = 4'd10;
	localparam logic [3:0] ST_DONE   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		cmd          = '0;
		cmd.frd_sel  = bfpb_pkg::FRD_USER;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				// power-up wipe of the frame store
				cmd.swp_step = 1'b1;
				if (sts.swp_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_n  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				unique case (sts.cmd)
					bfpb_pkg::CMD_LOAD: begin
						state_n = ST_MOD;
					end
					bfpb_pkg::CMD_BEGIN, bfpb_pkg::CMD_BEGIN_CTR: begin
						state_n = ST_BEGIN;
					end
					bfpb_pkg::CMD_DRAW: begin
						state_n = sts.draw_ok ? ST_MOD : ST_DONE;
					end
					bfpb_pkg::CMD_CLEAR: begin
						cmd.swp_load = sts.sec_ok;
						state_n      = sts.sec_ok ? ST_SWEEP : ST_DONE;
					end
					bfpb_pkg::CMD_READ: begin
						state_n = ST_RDW;
					end
					default: begin
						state_n = ST_DONE;
					end
				endcase
			end
			ST_MOD: begin
				cmd.red_step = 1'b1;
				if (sts.red_last) begin
					state_n = (sts.cmd == bfpb_pkg::CMD_LOAD) ? ST_LOADW : ST_GLY;
				end
			end
			ST_LOADW: begin
				cmd.gly_wr = 1'b1;
				state_n    = ST_DONE;
			end
			ST_BEGIN: begin
				cmd.begin_upd = 1'b1;
				state_n       = ST_DONE;
			end
			ST_SWEEP: begin
				cmd.swp_step = 1'b1;
				if (sts.swp_last) begin
					state_n = ST_DONE;
				end
			end
			ST_RDW: begin
				cmd.rd_cap = 1'b1;
				state_n    = ST_DONE;
			end
			ST_GLY: begin
				// glyph byte and cursor page byte read together
				cmd.frd_sel = bfpb_pkg::FRD_CUR;
				state_n     = ST_COL0;
			end
			ST_COL0: begin
				cmd.col0    = 1'b1;
				cmd.frd_sel = bfpb_pkg::FRD_NEXT;
				if (sts.shift_nz) begin
					state_n = ST_COL1;
				end else begin
					cmd.adv = 1'b1;
					state_n = sts.col_last ? ST_DONE : ST_GLY;
				end
			end
			ST_COL1: begin
				cmd.col1 = 1'b1;
				cmd.adv  = 1'b1;
				state_n  = sts.col_last ? ST_DONE : ST_GLY;
			end
			ST_DONE: begin
				if (sts.res_free) begin
					cmd.res_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/bfpb_dp.sv
`include "assert_macros.svh"

module bfpb_dp #(
	parameter int COLUMNS     = 128,
	parameter int PAGES       = 8,
	parameter int GLYPH_DEPTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bfpb_pkg::dp_cmd_t                    cmd,
	output bfpb_pkg::dp_sts_t                    sts,
	input  logic [bfpb_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic [2:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bfpb_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [0:0]                           m_tuser,
	input  logic                                 cfg_valid,
	input  logic [1:0]                           cfg_index,
	input  logic [7:0]                           cfg_data
);

	localparam int CW     = $clog2(COLUMNS);
	localparam int CCW    = $clog2(COLUMNS + 1);
	localparam int PGW    = $clog2(PAGES);
	localparam int GAW    = $clog2(GLYPH_DEPTH);
	localparam int FAW    = PGW + CW;
	localparam int FDEPTH = PAGES << CW;
	localparam int RW     = bfpb_pkg::RED_W;
	localparam int RXW    = RW + 5;

	localparam logic [CCW-1:0] COL_END   = CCW'(COLUMNS);
	localparam logic [CW-1:0]  COL_MAX   = CW'(COLUMNS - 1);
	localparam logic [8:0]     COL_END9  = 9'(COLUMNS);
	localparam logic [RW-1:0]  COL_END_R = RW'(COLUMNS);
	localparam logic [4:0]     PAGE_LIM  = 5'(PAGES);
	localparam logic [RXW-1:0] GD_X      = RXW'(GLYPH_DEPTH);
	localparam logic [RW-1:0]  GD_LAST   = RW'(GLYPH_DEPTH - 1);

	// item fields
	logic [2:0] cmd_q;
	logic [1:0] sec_q;
	logic [7:0] x_q;
	logic [2:0] row_q;
	logic [7:0] vsh_q;
	logic [7:0] len_q;
	logic [7:0] code_q;
	logic [10:0] gaddr_q;
	logic [7:0] gbyte_q;
	logic [2:0] rpage_q;
	logic [6:0] rcol_q;

	// configuration
	logic [4:0] width_q;
	logic [7:0] first_q;
	logic [7:0] last_q;

	// cursor
	logic [CCW-1:0] ccol_q;
	logic [3:0]     cpage_q;
	logic [2:0]     shift_q;

	logic [RW-1:0] red_q;
	logic [2:0]    stp_q;
	logic [4:0]    jq_q;
	logic [7:0]    g_q;

	logic [PGW-1:0] swp_page_q;
	logic [CW-1:0]  swp_col_q;
	logic [PGW-1:0] swp_end_q;

	logic       m_tvalid_q;
	logic [7:0] rdata_q;
	logic [7:0] out_rdata_q;
	logic [7:0] out_ccol_q;
	logic       out_status_q;

	logic           sec_ok;
	logic [3:0]     sec_first;
	logic [3:0]     sec_last;
	logic [4:0]     npage;
	logic           cpage_ok;
	logic           npage_ok;
	logic [7:0]     mul_a;
	logic [RW-1:0]  prod;
	logic [RXW-1:0] red_x;
	logic [RXW-1:0] dvs;
	logic [RW-1:0]  ctr_diff;
	logic [8:0]     x9;
	logic [8:0]     xc;
	logic [7:0]     gly_rd;
	logic [7:0]     fr_rd;
	logic [7:0]     up_bits;
	logic [7:0]     lo_bits;
	logic [3:0]     lo_sh;
	logic [CW-1:0]  ccol_idx;
	logic [FAW-1:0] fr_raddr;
	logic [FAW-1:0] fr_waddr;
	logic [7:0]     fr_wdata;
	logic           fr_we;
	logic           bad_sec;

	always_comb begin
		unique case (sec_q)
			bfpb_pkg::SEC_HEADER: begin
				sec_ok    = 1'b1;
				sec_first = bfpb_pkg::HEADER_FIRST_PAGE;
				sec_last  = bfpb_pkg::HEADER_LAST_PAGE;
			end
			bfpb_pkg::SEC_BODY: begin
				sec_ok    = 1'b1;
				sec_first = bfpb_pkg::BODY_FIRST_PAGE;
				sec_last  = bfpb_pkg::BODY_LAST_PAGE;
			end
			bfpb_pkg::SEC_FOOTER: begin
				sec_ok    = 1'b1;
				sec_first = bfpb_pkg::FOOTER_FIRST_PAGE;
				sec_last  = bfpb_pkg::FOOTER_LAST_PAGE;
			end
			default: begin
				sec_ok    = 1'b0;
				sec_first = '0;
				sec_last  = '0;
			end
		endcase
	end

	assign npage    = {1'b0, cpage_q} + 5'd1;
	assign cpage_ok = {1'b0, cpage_q} < PAGE_LIM;
	assign npage_ok = npage < PAGE_LIM;
	assign ccol_idx = ccol_q[CW-1:0];

	// glyph base for a draw, text width in columns for centering
	assign mul_a = (cmd_q == bfpb_pkg::CMD_DRAW) ? (code_q - first_q) : len_q;
	assign prod  = RW'({5'b0, mul_a} * {8'b0, width_q});

	assign red_x = {5'b0, red_q};
	assign dvs   = GD_X << stp_q;

	assign ctr_diff = COL_END_R - red_q;
	assign x9       = {1'b0, x_q};
	assign xc       = (x9 > COL_END9) ? COL_END9 : x9;

	assign up_bits = gly_rd << shift_q;
	assign lo_sh   = 4'd8 - {1'b0, shift_q};
	assign lo_bits = g_q >> lo_sh;

	assign bad_sec = !sec_ok && (cmd_q == bfpb_pkg::CMD_BEGIN ||
		cmd_q == bfpb_pkg::CMD_BEGIN_CTR || cmd_q == bfpb_pkg::CMD_CLEAR);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sec_q   <= s_tdata[1:0];
			x_q     <= s_tdata[9:2];
			row_q   <= s_tdata[12:10];
			vsh_q   <= s_tdata[20:13];
			len_q   <= s_tdata[28:21];
			code_q  <= s_tdata[36:29];
			gaddr_q <= s_tdata[47:37];
			gbyte_q <= s_tdata[55:48];
			rpage_q <= s_tdata[58:56];
			rcol_q  <= s_tdata[65:59];
			cmd_q   <= s_tuser;
		end
		if (cmd.decode) begin
			red_q <= (cmd_q == bfpb_pkg::CMD_LOAD) ? RW'(gaddr_q) : prod;
			stp_q <= bfpb_pkg::RED_TOP;
			jq_q  <= '0;
		end else if (cmd.red_step) begin
			// one restoring step of the modulo by the glyph memory depth
			if (red_x >= dvs) begin
				red_q <= RW'(red_x - dvs);
			end
			stp_q <= stp_q - 3'd1;
		end else if (cmd.adv) begin
			red_q <= (red_q == GD_LAST) ? '0 : red_q + RW'(1);
			jq_q  <= jq_q + 5'd1;
		end
		if (cmd.col0) begin
			g_q <= gly_rd;
		end
		if (cmd.take) begin
			rdata_q <= '0;
		end else if (cmd.rd_cap) begin
			rdata_q <= ({2'b0, rpage_q} < PAGE_LIM && {2'b0, rcol_q} < COL_END9) ? fr_rd : '0;
		end
		if (cmd.res_load) begin
			out_rdata_q  <= rdata_q;
			out_ccol_q   <= 8'(ccol_q);
			out_status_q <= bad_sec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= bfpb_pkg::GLYPH_WIDTH_RST;
			first_q    <= bfpb_pkg::FIRST_CODE_RST;
			last_q     <= bfpb_pkg::LAST_CODE_RST;
			ccol_q     <= COL_END;
			cpage_q    <= '0;
			shift_q    <= '0;
			swp_page_q <= '0;
			swp_col_q  <= '0;
			swp_end_q  <= PGW'(PAGES - 1);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bfpb_pkg::CFG_GLYPH_WIDTH: width_q <= cfg_data[4:0];
					bfpb_pkg::CFG_FIRST_CODE:  first_q <= cfg_data;
					bfpb_pkg::CFG_LAST_CODE:   last_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.begin_upd) begin
				if (!sec_ok) begin
					ccol_q <= COL_END;
				end else begin
					cpage_q <= sec_first + {1'b0, row_q};
					if (cmd_q == bfpb_pkg::CMD_BEGIN) begin
						shift_q <= (vsh_q > {5'b0, bfpb_pkg::SHIFT_MAX}) ?
							bfpb_pkg::SHIFT_MAX : vsh_q[2:0];
						ccol_q  <= CCW'(xc);
					end else begin
						shift_q <= '0;
						ccol_q  <= (red_q < COL_END_R) ? CCW'(ctr_diff >> 1) : '0;
					end
				end
			end else if (cmd.adv) begin
				ccol_q <= ccol_q + CCW'(1);
			end
			if (cmd.swp_load) begin
				swp_page_q <= PGW'(sec_first);
				swp_col_q  <= '0;
				swp_end_q  <= PGW'(sec_last);
			end else if (cmd.swp_step) begin
				if (swp_col_q == COL_MAX) begin
					swp_col_q  <= '0;
					swp_page_q <= swp_page_q + PGW'(1);
				end else begin
					swp_col_q <= swp_col_q + CW'(1);
				end
			end
			if (cmd.res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// frame store port selection
	always_comb begin
		unique case (cmd.frd_sel)
			bfpb_pkg::FRD_CUR:  fr_raddr = {PGW'(cpage_q), ccol_idx};
			bfpb_pkg::FRD_NEXT: fr_raddr = {PGW'(npage), ccol_idx};
			default:            fr_raddr = {PGW'(rpage_q), CW'(rcol_q)};
		endcase
	end

	always_comb begin
		fr_we    = cmd.swp_step;
		fr_waddr = {swp_page_q, swp_col_q};
		fr_wdata = '0;
		if (cmd.col0) begin
			fr_we    = cpage_ok;
			fr_waddr = {PGW'(cpage_q), ccol_idx};
			fr_wdata = (shift_q != '0) ? (fr_rd | up_bits) : gly_rd;
		end else if (cmd.col1) begin
			fr_we    = npage_ok;
			fr_waddr = {PGW'(npage), ccol_idx};
			fr_wdata = fr_rd | lo_bits;
		end
	end

	bfpb_ram #(
		.WIDTH(8),
		.DEPTH(FDEPTH)
	) u_frame (
		.clk  (clk),
		.we   (fr_we),
		.waddr(fr_waddr),
		.wdata(fr_wdata),
		.raddr(fr_raddr),
		.rdata(fr_rd)
	);

	bfpb_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_DEPTH)
	) u_glyph (
		.clk  (clk),
		.we   (cmd.gly_wr),
		.waddr(red_q[GAW-1:0]),
		.wdata(gbyte_q),
		.raddr(red_q[GAW-1:0]),
		.rdata(gly_rd)
	);

	always_comb begin
		sts.cmd      = cmd_q;
		sts.sec_ok   = sec_ok;
		sts.draw_ok  = (ccol_q < COL_END) && (code_q >= first_q) && (code_q <= last_q) &&
			(width_q != '0);
		sts.shift_nz = shift_q != '0;
		sts.red_last = stp_q == '0;
		sts.swp_last = (swp_col_q == COL_MAX) && (swp_page_q == swp_end_q);
		sts.col_last = ({1'b0, jq_q} + 6'd1 == {1'b0, width_q}) ||
			(ccol_q + CCW'(1) == COL_END);
		sts.res_free = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_ccol_q, out_rdata_q};
	assign m_tuser  = out_status_q;

	`ASSERT_NEVER(a_res_overrun, cmd.res_load && m_tvalid_q && !m_tready, "result beat overwritten")
	`ASSERT_IMPLY(a_draw_col, cmd.col0 || cmd.col1, ccol_q < COL_END, "draw past last column")
	`ASSERT_IMPLY(a_glyph_addr, cmd.gly_wr || cmd.col0, red_q <= GD_LAST, "glyph address not reduced")

endmodule
